@@ rtl/ray_box_hit_distance_core_defines.svh @@
// Assertion macros for the ray/box hit distance core.
// Used by ray_box_hit_distance_core.sv; no other dependencies.
`ifndef RAY_BOX_HIT_DISTANCE_CORE_DEFINES_SVH
`define RAY_BOX_HIT_DISTANCE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RBHD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbhd assertion failed");

// Next-cycle implication, disabled during reset.
`define RBHD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbhd assertion failed");

`endif

@@ rtl/rbhd_pkg.sv @@
// Shared types and constants for the ray/box hit distance core.
// No dependencies.
package rbhd_pkg;

   localparam int unsigned CoordBits    = 32;
   localparam int unsigned CsrIndexBits = 3;

   typedef logic signed [CoordBits-1:0] coord_type;
   typedef logic        [CoordBits-1:0] dist_type;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_DIR_X    = 3'd3,
      CSR_DIR_Y    = 3'd4,
      CSR_DIR_Z    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic      box_valid;
      coord_type box_min_x;
      coord_type box_min_y;
      coord_type box_min_z;
      coord_type box_max_x;
      coord_type box_max_y;
      coord_type box_max_z;
   } box_type;

   typedef struct packed {
      logic     hit_found;
      dist_type hit_distance;
   } hit_type;

endpackage

@@ rtl/rbhd_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; instantiated by ray_box_hit_distance_core.
module rbhd_div_pipe #(
   parameter int unsigned QUOT_BITS = 32,
   parameter int unsigned TOP_BITS  = 16
) (
   input  logic                 clock,
   input  logic [TOP_BITS-1:0]  num_top,   // must be below den for a valid quotient
   input  logic [QUOT_BITS-1:0] num_low,
   input  logic [QUOT_BITS-1:0] den,
   output logic [QUOT_BITS-1:0] quot
);

   logic [QUOT_BITS-1:0] rem_ff  [QUOT_BITS-1];
   logic [QUOT_BITS-1:0] low_ff  [QUOT_BITS-1];
   logic [QUOT_BITS-1:0] den_ff  [QUOT_BITS-1];
   logic [QUOT_BITS-1:0] quot_ff [QUOT_BITS];

   for (genvar i = 0; i < QUOT_BITS; i++) begin : g_stage
      logic [QUOT_BITS-1:0] rem_prev;
      logic [QUOT_BITS-1:0] low_prev;
      logic [QUOT_BITS-1:0] den_prev;
      logic [QUOT_BITS-1:0] quot_prev;
      logic [QUOT_BITS:0]   trial;
      logic [QUOT_BITS:0]   diff;
      logic                 ge;

      if (i == 0) begin : g_first
         assign rem_prev  = QUOT_BITS'(num_top);
         assign low_prev  = num_low;
         assign den_prev  = den;
         assign quot_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign low_prev  = low_ff[i-1];
         assign den_prev  = den_ff[i-1];
         assign quot_prev = quot_ff[i-1];
      end

      assign trial = {rem_prev, low_prev[QUOT_BITS-1]};
      assign ge    = trial >= {1'b0, den_prev};
      assign diff  = trial - {1'b0, den_prev};

      always_ff @(posedge clock) begin
         quot_ff[i] <= {quot_prev[QUOT_BITS-2:0], ge};
      end

      if (i < QUOT_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[i] <= ge ? diff[QUOT_BITS-1:0] : trial[QUOT_BITS-1:0];
            low_ff[i] <= {low_prev[QUOT_BITS-2:0], 1'b0};
            den_ff[i] <= den_prev;
         end
      end
   end

   assign quot = quot_ff[QUOT_BITS-1];

endmodule

@@ rtl/ray_box_hit_distance_core.sv @@
// Ray versus axis-aligned box test with nearest hit distance.
// Depends on rbhd_pkg, rbhd_div_pipe and ray_box_hit_distance_core_defines.svh.
//
// Usage:
//  - Ray origin and direction (signed Q16.16) sit in six CSRs written through
//    csr_we/csr_index/csr_wdata; write them only while no box is in flight.
//    Indexes beyond the last register are ignored.
//  - A box transfers in at each rising edge with start high and busy low.
//    busy is always low: one box per cycle is sustained.
//  - Exactly one result per box on rsp_hit, marked by a one-cycle rsp_valid
//    strobe, in order.
//    The receiver cannot stall; results are never held.
//  - Pipeline: input reg, slab/candidate reg, 32-stage divider per axis
//    (sets the latency), t reg, multiplier reg, point-check reg, output reg.
//  - Synchronous reset clears the CSRs to zero and drops every item in flight.
`include "ray_box_hit_distance_core_defines.svh"

module ray_box_hit_distance_core #(
   parameter int unsigned FRAC_BITS = 16     // 4..32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // box input
   input  logic                                  start,
   output logic                                  busy,
   input  rbhd_pkg::box_type                     req_box,
   // result
   output logic                                  rsp_valid,
   output rbhd_pkg::hit_type                     rsp_hit,
   // CSR write port
   input  logic                                  csr_we,
   input  logic [rbhd_pkg::CsrIndexBits-1:0]     csr_index,
   input  logic [rbhd_pkg::CoordBits-1:0]        csr_wdata
);

   import rbhd_pkg::*;

   localparam int unsigned NumBits = CoordBits + FRAC_BITS;   // dividend width
   localparam int unsigned ProdBits = 2 * CoordBits;
   localparam int unsigned PntBits = ProdBits + 2;            // hit point, no wrap
   localparam int unsigned Latency = CoordBits + 6;

   typedef struct packed {
      logic       in_box;
      logic [2:0] cand;
      logic [2:0] sat;
      box_type    box;
   } side_type;

   typedef struct packed {
      logic                in_box;
      logic [2:0]          cand;    // after the point check: face hit per axis
      dist_type [2:0]      t;
      box_type             box;
   } item_type;

   function automatic coord_type lo_of(box_type b, int unsigned a);
      case (a)
         0:       return b.box_min_x;
         1:       return b.box_min_y;
         default: return b.box_min_z;
      endcase
   endfunction

   function automatic coord_type hi_of(box_type b, int unsigned a);
      case (a)
         0:       return b.box_max_x;
         1:       return b.box_max_y;
         default: return b.box_max_z;
      endcase
   endfunction

   // ---------------------------------------------------------------- CSRs
   coord_type origin_ff [3];
   coord_type dir_ff    [3];
   dist_type  dmag_ff   [3];   // |dir| per axis, registered from dir_ff

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '{default: '0};
         dir_ff    <= '{default: '0};
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_X: origin_ff[0] <= csr_wdata;
            CSR_ORIGIN_Y: origin_ff[1] <= csr_wdata;
            CSR_ORIGIN_Z: origin_ff[2] <= csr_wdata;
            CSR_DIR_X:    dir_ff[0]    <= csr_wdata;
            CSR_DIR_Y:    dir_ff[1]    <= csr_wdata;
            CSR_DIR_Z:    dir_ff[2]    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         dmag_ff[a] <= dir_ff[a][CoordBits-1] ? dist_type'(-dir_ff[a]) : dist_type'(dir_ff[a]);
      end
   end

   assign busy = 1'b0;

   // ---------------------------------------------------------------- S1: input
   logic    s1_valid_ff;
   box_type s1_box_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= start && !busy;
   end

   always_ff @(posedge clock) begin
      s1_box_ff <= req_box;
   end

   // ---------------------------------------------------------------- S2: slabs
   // Per axis at most one face can face the ray, picked by the direction sign.
   logic       s2_valid_ff;
   box_type    s2_box_ff;
   logic       s2_inside_ff, s2_inside_in;
   logic [2:0] s2_cand_ff, s2_cand_in;
   dist_type   s2_mag_ff [3];
   dist_type   s2_mag_in [3];

   always_comb begin
      coord_type            lo, hi, o, d;
      logic                 cand_lo, cand_hi;
      logic [CoordBits:0]   gap_lo, gap_hi;
      s2_inside_in = 1'b1;
      for (int a = 0; a < 3; a++) begin
         lo = lo_of(s1_box_ff, a);
         hi = hi_of(s1_box_ff, a);
         o  = origin_ff[a];
         d  = dir_ff[a];
         s2_inside_in  = s2_inside_in && (o >= lo) && (o <= hi);
         cand_lo       = (o < lo) && !d[CoordBits-1] && (d != '0);
         cand_hi       = (o > hi) && d[CoordBits-1];
         s2_cand_in[a] = cand_lo || cand_hi;
         gap_lo        = {lo[CoordBits-1], lo} - {o[CoordBits-1], o};
         gap_hi        = {o[CoordBits-1], o} - {hi[CoordBits-1], hi};
         s2_mag_in[a]  = cand_hi ? gap_hi[CoordBits-1:0] : gap_lo[CoordBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      s2_box_ff    <= s1_box_ff;
      s2_inside_ff <= s2_inside_in;
      s2_cand_ff   <= s2_cand_in;
      s2_mag_ff    <= s2_mag_in;
   end

   // ---------------------------------------------------------------- divide
   // t = gap * 2^FRAC / |dir|; quotients at or above 2^COORD saturate, so the
   // divider only has to produce the low COORD bits.
   logic [2:0] s2_sat;
   dist_type   quot [3];

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic [NumBits-1:0] num;
      assign num       = {s2_mag_ff[a], {FRAC_BITS{1'b0}}};
      assign s2_sat[a] = NumBits'(num[NumBits-1:CoordBits]) >= NumBits'(dmag_ff[a]);

      rbhd_div_pipe #(
         .QUOT_BITS (CoordBits),
         .TOP_BITS  (FRAC_BITS)
      ) u_div (
         .clock   (clock),
         .num_top (num[NumBits-1:CoordBits]),
         .num_low (num[CoordBits-1:0]),
         .den     (dmag_ff[a]),
         .quot    (quot[a])
      );
   end

   // side data rides along with the divider stages
   logic [CoordBits-1:0] dl_valid_ff;
   side_type             dl_ff [CoordBits];
   side_type             dl_in;

   always_comb begin
      dl_in.in_box = s2_inside_ff;
      dl_in.cand   = s2_cand_ff;
      dl_in.sat    = s2_sat;
      dl_in.box    = s2_box_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) dl_valid_ff <= '0;
      else       dl_valid_ff <= {dl_valid_ff[CoordBits-2:0], s2_valid_ff};
   end

   always_ff @(posedge clock) begin
      dl_ff[0] <= dl_in;
      for (int i = 1; i < CoordBits; i++) begin
         dl_ff[i] <= dl_ff[i-1];
      end
   end

   // ---------------------------------------------------------------- S3: t
   logic     s3_valid_ff;
   item_type s3_item_ff, s3_item_in;

   always_comb begin
      s3_item_in.in_box = dl_ff[CoordBits-1].in_box;
      s3_item_in.cand   = dl_ff[CoordBits-1].cand;
      s3_item_in.box    = dl_ff[CoordBits-1].box;
      for (int a = 0; a < 3; a++) begin
         s3_item_in.t[a] = dl_ff[CoordBits-1].sat[a] ? '1 : quot[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= dl_valid_ff[CoordBits-1];
   end

   always_ff @(posedge clock) begin
      s3_item_ff <= s3_item_in;
   end

   // ---------------------------------------------------------------- S4/S5
   // S4 registers t * |dir_k| for the two other axes; S5 registers the
   // inclusive hit-point check.
   logic                s4_valid_ff;
   item_type            s4_item_ff;
   logic [ProdBits-1:0] prod_ff [3][2];
   logic [5:0]          chk_ok;

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else       s4_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      s4_item_ff <= s3_item_ff;
   end

   for (genvar a = 0; a < 3; a++) begin : g_face
      for (genvar j = 0; j < 2; j++) begin : g_other
         localparam int unsigned K = (a + 1 + j) % 3;
         logic [ProdBits-1:0]      off;
         logic signed [PntBits-1:0] pnt, org, lo, hi, offx;

         always_ff @(posedge clock) begin
            prod_ff[a][j] <= s3_item_ff.t[a] * dmag_ff[K];
         end

         assign off  = prod_ff[a][j] >> FRAC_BITS;
         assign offx = $signed(PntBits'(off));
         assign org  = PntBits'(origin_ff[K]);
         assign lo   = PntBits'(lo_of(s4_item_ff.box, K));
         assign hi   = PntBits'(hi_of(s4_item_ff.box, K));
         assign pnt  = dir_ff[K][CoordBits-1] ? org - offx : org + offx;
         assign chk_ok[2*a+j] = (pnt >= lo) && (pnt <= hi);
      end
   end

   logic     s5_valid_ff;
   item_type s5_item_ff, s5_item_in;

   always_comb begin
      s5_item_in = s4_item_ff;
      for (int a = 0; a < 3; a++) begin
         s5_item_in.cand[a] = s4_item_ff.cand[a] && chk_ok[2*a] && chk_ok[2*a+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s5_valid_ff <= 1'b0;
      else       s5_valid_ff <= s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      s5_item_ff <= s5_item_in;
   end

   // ---------------------------------------------------------------- output
   // Faces in x, y, z order; a later one wins only with a strictly smaller t.
   logic    rsp_valid_ff;
   hit_type rsp_hit_ff, rsp_hit_in;

   always_comb begin
      logic     found;
      dist_type best;
      found = 1'b0;
      best  = '1;
      for (int a = 0; a < 3; a++) begin
         if (s5_item_ff.cand[a] && (!found || (s5_item_ff.t[a] < best))) begin
            found = 1'b1;
            best  = s5_item_ff.t[a];
         end
      end
      if (!s5_item_ff.box.box_valid) begin
         rsp_hit_in.hit_found    = 1'b0;
         rsp_hit_in.hit_distance = '1;
      end else if (s5_item_ff.in_box) begin
         rsp_hit_in.hit_found    = 1'b1;
         rsp_hit_in.hit_distance = '0;
      end else begin
         rsp_hit_in.hit_found    = found;
         rsp_hit_in.hit_distance = best;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= s5_valid_ff;
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= rsp_hit_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   // ---------------------------------------------------------------- checks
   `RBHD_ASSERT_IMPLIES(a_rsp_has_req, clock, reset, rsp_valid, $past(start && !busy, Latency))
   `RBHD_ASSERT_IMPLIES(a_miss_is_inf, clock, reset, rsp_valid && !rsp_hit.hit_found, rsp_hit.hit_distance == '1)
   `RBHD_ASSERT_NEXT(a_invalid_miss, clock, reset, s5_valid_ff && !s5_item_ff.box.box_valid, rsp_valid && !rsp_hit.hit_found)

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for ray_box_hit_distance_core.
// Depends on rbhd_pkg and the core RTL; an internal predictor checks every result in order.

module testbench;
   import rbhd_pkg::*;

   localparam int  PIPE_DRAIN  = 40;
   localparam int  CYCLE_LIMIT = 300000;
   localparam longint DIST_SAT = 64'hFFFF_FFFF;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   box_type                 req_box;
   logic                    rsp_valid;
   hit_type                 rsp_hit;
   logic                    csr_we;
   logic [CsrIndexBits-1:0] csr_index;
   logic [CoordBits-1:0]    csr_wdata;

   ray_box_hit_distance_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_box   (req_box),
      .rsp_valid (rsp_valid),
      .rsp_hit   (rsp_hit),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Local copy of the ray registers: origin x,y,z then direction x,y,z.
   coord_type ray_reg [6];

   box_type pending_boxes [$];     // filled by the stimulus thread
   hit_type expected_hits [$];     // predicted results, oldest first
   int      fail_count = 0;
   int      cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor: exact integer version of the slab/face test.
   // ---------------------------------------------------------------------
   function automatic longint unsigned abs_val(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic hit_type nearest_hit(box_type b);
      longint o [3], d [3], lo [3], hi [3];
      longint bound, p;
      longint unsigned t, best, offs;
      hit_type r;
      bit found, in_box, ok;
      int a;
      o[0] = ray_reg[0];  o[1] = ray_reg[1];  o[2] = ray_reg[2];
      d[0] = ray_reg[3];  d[1] = ray_reg[4];  d[2] = ray_reg[5];
      lo[0] = b.box_min_x; lo[1] = b.box_min_y; lo[2] = b.box_min_z;
      hi[0] = b.box_max_x; hi[1] = b.box_max_y; hi[2] = b.box_max_z;
      r.hit_found    = 1'b0;
      r.hit_distance = '1;
      if (!b.box_valid) return r;
      in_box = 1'b1;
      for (int k = 0; k < 3; k++)
         if (o[k] < lo[k] || o[k] > hi[k]) in_box = 1'b0;
      if (in_box) begin
         r.hit_found    = 1'b1;
         r.hit_distance = '0;
         return r;
      end
      found = 1'b0;
      best  = DIST_SAT;
      // faces in order -x,+x,-y,+y,-z,+z
      for (int f = 0; f < 6; f++) begin
         a = f / 2;
         if (f % 2 == 0) begin
            if (!(o[a] < lo[a] && d[a] > 0)) continue;
            bound = lo[a];
         end else begin
            if (!(o[a] > hi[a] && d[a] < 0)) continue;
            bound = hi[a];
         end
         t = (abs_val(bound - o[a]) << 16) / abs_val(d[a]);
         if (t > DIST_SAT) t = DIST_SAT;
         if (found && t >= best) continue;
         ok = 1'b1;
         for (int k = 0; k < 3; k++) begin
            if (k == a) continue;
            offs = (t * abs_val(d[k])) >> 16;
            p = (d[k] < 0) ? o[k] - longint'(offs) : o[k] + longint'(offs);
            if (p < lo[k] || p > hi[k]) ok = 1'b0;
         end
         if (ok) begin
            found = 1'b1;
            best  = t;
         end
      end
      if (found) begin
         r.hit_found    = 1'b1;
         r.hit_distance = best[31:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: bursts of transfers separated by random gaps.
   // ---------------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         req_box    <= '0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         automatic bit can_issue = !(start && busy);
         // transfer completes on this edge
         if (start && !busy) expected_hits.push_back(nearest_hit(req_box));
         if (!can_issue) begin
            // hold the item until busy drops
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (pending_boxes.size() > 0) begin
            start   <= 1'b1;
            req_box <= pending_boxes.pop_front();
            if (burst_left <= 1) begin
               // a third of the bursts run with no gap at all afterwards
               burst_left <= $urandom_range(1, 60);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every strobed result against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_hits.size() == 0) begin
            $error("result with no transfer outstanding: found=%0b dist=%h",
                   rsp_hit.hit_found, rsp_hit.hit_distance);
            fail_count++;
         end else begin
            automatic hit_type exp_hit = expected_hits.pop_front();
            if (rsp_hit.hit_found !== exp_hit.hit_found) begin
               $error("hit_found: expected %0b actual %0b",
                      exp_hit.hit_found, rsp_hit.hit_found);
               fail_count++;
            end
            if (rsp_hit.hit_distance !== exp_hit.hit_distance) begin
               $error("hit_distance: expected %h actual %h",
                      exp_hit.hit_distance, rsp_hit.hit_distance);
               fail_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic box_type make_box(bit v, coord_type x0, coord_type y0, coord_type z0,
                                        coord_type x1, coord_type y1, coord_type z1);
      box_type b;
      b.box_valid = v;
      b.box_min_x = x0; b.box_min_y = y0; b.box_min_z = z0;
      b.box_max_x = x1; b.box_max_y = y1; b.box_max_z = z1;
      return b;
   endfunction

   // Mostly small coordinates so that hits are common; some full range and extremes.
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom;
         2:       return ($urandom_range(0, 1) == 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      endcase
   endfunction

   function automatic coord_type clamp_coord(longint v);
      if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // Box placed around a point on the ray, so that most of these are hit.
   function automatic box_type aimed_box();
      longint unsigned t;
      longint pt [3];
      longint lo_c [3], hi_c [3];
      t = $urandom_range(0, 32'h0010_0000);
      for (int k = 0; k < 3; k++) begin
         automatic longint dk = ray_reg[3+k];
         automatic longint unsigned offs = (t * abs_val(dk)) >> 16;
         pt[k]   = (dk < 0) ? longint'(ray_reg[k]) - longint'(offs)
                            : longint'(ray_reg[k]) + longint'(offs);
         lo_c[k] = pt[k] - $urandom_range(0, 32'h0002_0000);
         hi_c[k] = pt[k] + $urandom_range(0, 32'h0002_0000);
      end
      return make_box($urandom_range(0, 19) != 0,
                      clamp_coord(lo_c[0]), clamp_coord(lo_c[1]), clamp_coord(lo_c[2]),
                      clamp_coord(hi_c[0]), clamp_coord(hi_c[1]), clamp_coord(hi_c[2]));
   endfunction

   function automatic box_type random_box();
      coord_type a [6];
      box_type b;
      for (int k = 0; k < 6; k++) a[k] = rand_coord();
      // usually ordered bounds; sometimes left inverted
      if ($urandom_range(0, 7) != 0)
         for (int k = 0; k < 3; k++)
            if (a[k] > a[k+3]) begin
               automatic coord_type tmp = a[k];
               a[k] = a[k+3];
               a[k+3] = tmp;
            end
      b = make_box($urandom_range(0, 9) != 0, a[0], a[1], a[2], a[3], a[4], a[5]);
      return b;
   endfunction

   task automatic csr_write(logic [CsrIndexBits-1:0] idx, logic [CoordBits-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx < 6) ray_reg[idx] = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_ray(coord_type ox, coord_type oy, coord_type oz,
                          coord_type dx, coord_type dy, coord_type dz);
      csr_write(CSR_ORIGIN_X, ox);
      csr_write(CSR_ORIGIN_Y, oy);
      csr_write(CSR_ORIGIN_Z, oz);
      csr_write(CSR_DIR_X, dx);
      csr_write(CSR_DIR_Y, dy);
      csr_write(CSR_DIR_Z, dz);
   endtask

   // Waits until every box has been sent and every prediction matched, then lets the pipe settle.
   task automatic drain();
      while (pending_boxes.size() != 0 || start || expected_hits.size() != 0)
         @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic random_phase(int n);
      repeat (n) begin
         if ($urandom_range(0, 9) < 6) pending_boxes.push_back(aimed_box());
         else                          pending_boxes.push_back(random_box());
      end
      drain();
   endtask

   function automatic coord_type rand_dir();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return $urandom;
         default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (int k = 0; k < 6; k++) ray_reg[k] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset ray: origin at zero, zero direction, so only origin-inside can hit.
      pending_boxes.push_back(make_box(1'b1, -32'sh10000, -32'sh10000, -32'sh10000,
                                       32'sh10000, 32'sh10000, 32'sh10000));
      pending_boxes.push_back(make_box(1'b0, -32'sh10000, -32'sh10000, -32'sh10000,
                                       32'sh10000, 32'sh10000, 32'sh10000));
      pending_boxes.push_back(make_box(1'b1, 0, 0, 0, 0, 0, 0));   // inclusive bounds
      pending_boxes.push_back(make_box(1'b1, 32'sh10000, 0, 0, 32'sh20000, 0, 0));
      pending_boxes.push_back(make_box(1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                       32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      pending_boxes.push_back(make_box(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                       32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
      drain();

      // Indexes past the last register must be ignored.
      csr_write(3'd6, 32'hDEAD_BEEF);
      csr_write(3'd7, 32'h1234_5678);

      // Ray from (-4,0,0) along +x with a small y slope.
      set_ray(-32'sh40000, 0, 0, 32'sh10000, 32'sh8000, 0);
      pending_boxes.push_back(make_box(1'b1, -32'sh20000, -32'sh10000, -32'sh10000,
                                       32'sh20000, 32'sh10000, 32'sh10000));
      pending_boxes.push_back(make_box(1'b1, -32'sh20000, 32'sh10000, -32'sh10000,
                                       32'sh20000, 32'sh20000, 32'sh10000)); // grazes y edge
      pending_boxes.push_back(make_box(1'b1, -32'sh20000, 32'sh50000, 0,
                                       32'sh20000, 32'sh60000, 0));          // misses
      pending_boxes.push_back(make_box(1'b1, -32'sh80000, -32'sh10000, -32'sh10000,
                                       -32'sh60000, 32'sh10000, 32'sh10000)); // behind
      pending_boxes.push_back(make_box(1'b1, 32'sh20000, -32'sh10000, -32'sh10000,
                                       -32'sh20000, 32'sh10000, 32'sh10000)); // inverted
      drain();

      // Diagonal ray: +x/+y/+z faces tie at equal t.
      set_ray(32'sh40000, 32'sh40000, 32'sh40000, -32'sh10000, -32'sh10000, -32'sh10000);
      pending_boxes.push_back(make_box(1'b1, -32'sh10000, -32'sh10000, -32'sh10000,
                                       32'sh10000, 32'sh10000, 32'sh10000));
      pending_boxes.push_back(make_box(1'b1, -32'sh10000, -32'sh10000, -32'sh10000,
                                       32'sh10000, 32'sh20000, 32'sh30000));
      drain();

      // Extremes: far origin, tiny direction, t saturates.
      set_ray(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 32'sh1, 0, 32'sh8000_0000);
      pending_boxes.push_back(make_box(1'b1, 32'sh7FFF_FFFF, -32'sh10000, 32'sh8000_0000,
                                       32'sh7FFF_FFFF, 32'sh10000, 32'sh7FFF_FFFF));
      pending_boxes.push_back(make_box(1'b1, 32'sh7FFF_FFFF, 0, 32'sh8000_0000,
                                       32'sh7FFF_FFFF, 0, 32'sh8000_0000));
      pending_boxes.push_back(make_box(1'b1, 0, 0, 0, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF));
      drain();

      // Extreme registers with random boxes.
      set_ray(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
      random_phase(100);

      // Random rays.
      for (int ph = 0; ph < 8; ph++) begin
         set_ray(rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(), rand_dir());
         random_phase(200);
      end

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
